### design/pteh_pkg.sv
//------------------------------------------------------------------------------
// pteh_pkg
// Shared types, constants and helpers of the per-track energy histogrammer.
//------------------------------------------------------------------------------
package pteh_pkg;

  localparam int NUM_GROUPS   = 16;
  localparam int ENERGY_BITS  = 48;
  localparam int CNT_BITS     = 32;
  localparam int TRACK_BITS   = 31;
  localparam int FIELD_E_BITS = ENERGY_BITS;
  localparam int DEP_BITS     = 32;
  localparam int IDX_BITS     = $clog2(NUM_GROUPS + 1);
  localparam int CFG_BITS     = $clog2(NUM_GROUPS + 1);

  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_GAMMA    = 2'd0;
  localparam logic [1:0] KIND_ELECTRON = 2'd1;
  localparam logic [1:0] KIND_NEUTRON  = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic [TRACK_BITS-1:0]    track_id;
    logic [1:0]               particle_kind;
    logic [DEP_BITS-1:0]      energy_deposit;
    logic [IDX_BITS-1:0]      group_index;
    logic [FIELD_E_BITS-1:0]  group_low;
    logic [FIELD_E_BITS-1:0]  group_high;
  } in_item_t;

  typedef struct packed {
    logic                     track_closed;
    logic                     closed_class;
    logic [FIELD_E_BITS-1:0]  closed_energy;
    logic [IDX_BITS-1:0]      closed_bin;
    logic                     overflow_hit;
    logic [FIELD_E_BITS-1:0]  primary_energy;
    logic [FIELD_E_BITS-1:0]  gamma_total;
    logic [FIELD_E_BITS-1:0]  electron_total;
    logic [CNT_BITS-1:0]      neutron_tracks;
    logic [CNT_BITS-1:0]      bin_count;
  } out_item_t;

  function automatic logic [CNT_BITS-1:0] cnt_inc(input logic [CNT_BITS-1:0] c);
    cnt_inc = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

### design/pteh_in_if.sv
//------------------------------------------------------------------------------
// pteh_in_if
// Input channel: valid/ready handshake carrying one step or command item.
//------------------------------------------------------------------------------
interface pteh_in_if;
  logic               valid;
  logic               ready;
  pteh_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/pteh_out_if.sv
//------------------------------------------------------------------------------
// pteh_out_if
// Result channel: valid/ready handshake carrying one result item.
//------------------------------------------------------------------------------
interface pteh_out_if;
  logic                valid;
  logic                ready;
  pteh_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/pteh_ram.sv
//------------------------------------------------------------------------------
// pteh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
module pteh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/pteh_front.sv
//------------------------------------------------------------------------------
// pteh_front
// Front end: queues items, holds the group count and edges, and classifies
// the sum that the item at the queue head would close.
//------------------------------------------------------------------------------
module pteh_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pteh_pkg::CFG_BITS-1:0] cfg_wdata,
  pteh_in_if.sink                       in_ch,
  // Queue head toward the back end.
  output logic                          head_valid,
  input  logic                          head_pop,
  output pteh_pkg::in_item_t            head_item,
  // Edge lookup for the sum that the head item would close.
  input  logic [pteh_pkg::ENERGY_BITS-1:0] close_sum,
  output logic [pteh_pkg::IDX_BITS-1:0]    close_hit,
  output logic                             close_ovf
);
  import pteh_pkg::*;

  localparam int GB = IDX_BITS;
  localparam int EB = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  logic [ENERGY_BITS-1:0] lo_r [NUM_GROUPS];
  logic [ENERGY_BITS-1:0] hi_r [NUM_GROUPS];
  logic [GB-1:0]          gcount_r;
  logic [GB-1:0]          cfg_clamp;
  logic [EB-1:0]          last_g;
  in_item_t               q_r [2];
  logic                   qwp_r, qrp_r;
  logic [1:0]             qcnt_r;
  logic                   in_acc;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamp = GB'(1);
    end else if (32'(cfg_wdata) > NUM_GROUPS) begin
      cfg_clamp = GB'(NUM_GROUPS);
    end else begin
      cfg_clamp = GB'(cfg_wdata);
    end
  end

  assign in_ch.ready = (qcnt_r != 2'd2);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign head_valid  = (qcnt_r != 2'd0);
  assign head_item   = q_r[qrp_r];
  assign last_g      = EB'(gcount_r - GB'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcount_r <= GB'((NUM_GROUPS < 16) ? NUM_GROUPS : 16);
    end else if (cfg_we) begin
      gcount_r <= cfg_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qwp_r  <= 1'b0;
      qrp_r  <= 1'b0;
      qcnt_r <= 2'd0;
    end else begin
      if (in_acc) begin
        qwp_r <= ~qwp_r;
      end
      if (head_pop) begin
        qrp_r <= ~qrp_r;
      end
      qcnt_r <= qcnt_r + 2'(in_acc) - 2'(head_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[qwp_r] <= in_ch.data;
    end
  end

  // Edges change when the load item leaves the queue, so items queued ahead
  // of it still see the old edges.
  always_ff @(posedge clk) begin
    if (head_pop && head_item.command == CMD_LOAD
        && 32'(head_item.group_index) < NUM_GROUPS) begin
      lo_r[head_item.group_index[EB-1:0]] <= ENERGY_BITS'(head_item.group_low);
      hi_r[head_item.group_index[EB-1:0]] <= ENERGY_BITS'(head_item.group_high);
    end
  end

  always_comb begin
    close_hit = GB'(NUM_GROUPS);
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (g < int'(gcount_r) && lo_r[g] <= close_sum && close_sum < hi_r[g]) begin
        close_hit = GB'(g);
      end
    end
    close_ovf = close_sum >= hi_r[last_g];
  end

  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) qcnt_r != 2'd3)
    else $error("queue count out of range");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_valid) else $error("pop from an empty queue");
endmodule

### design/per_track_energy_histogrammer.sv
//------------------------------------------------------------------------------
// per_track_energy_histogrammer
// Per-track energy accumulation with group histogramming of closed tracks.
//------------------------------------------------------------------------------
// Each accepted item gives exactly one result. An item waits in a two-entry
// queue, then the back end reads the bin RAM as the item leaves the queue,
// does the bin write-back and the running totals in S_EXEC, and completes
// the result register in S_DONE. The next item leaves the queue only once
// the result has been taken, so the back end holds one item at a time; the
// queue keeps accepting up to two items meanwhile. Group edges are compared
// in parallel against the closed sum.
module per_track_energy_histogrammer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pteh_pkg::CFG_BITS-1:0] cfg_wdata,
  pteh_in_if.sink                       in_ch,
  pteh_out_if.source                    out_ch
);
  import pteh_pkg::*;

  localparam int GB    = IDX_BITS;
  localparam int NBINS = NUM_GROUPS + 1;
  localparam int BAB   = $clog2(2 * NBINS);
  localparam logic [ENERGY_BITS-1:0] EMAX = '1;

  typedef enum logic [1:0] { S_IDLE, S_EXEC, S_DONE } st_t;
  st_t st_r;

  in_item_t               cur_r;
  logic [TRACK_BITS-1:0]  last_r;
  logic [CNT_BITS-1:0]    gcnt_r, ecnt_r, ncnt_r;
  logic [ENERGY_BITS-1:0] gsum_r, esum_r, gtot_r, etot_r, psum_r;
  logic [NBINS-1:0]       gval_r, eval_r;
  out_item_t              o_r;
  logic                   ov_r;

  // Per-step decode done at queue head.
  in_item_t               hd;
  logic                   hd_valid, q_pop;
  logic                   hd_el, hd_cls, hd_close;
  logic [ENERGY_BITS-1:0] hd_sum;
  logic [GB-1:0]          hit;
  logic                   ovf;

  pteh_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .in_ch(in_ch),
    .head_valid(hd_valid), .head_pop(q_pop), .head_item(hd),
    .close_sum(hd_sum), .close_hit(hit), .close_ovf(ovf)
  );

  assign hd_el  = hd.particle_kind == KIND_ELECTRON;
  assign hd_cls = hd.command == CMD_STEP && hd.particle_kind[1] == 1'b0
                  && hd.track_id > TRACK_BITS'(1) && hd.track_id != last_r;
  assign hd_close = hd_cls && ((hd_el ? ecnt_r : gcnt_r) != '0);
  assign hd_sum = hd_el ? esum_r : gsum_r;

  // Bin RAM: gamma bins at 0..NBINS-1, electron bins at NBINS.. .
  // Overflow increments go to a separate pair of registers.
  logic [BAB-1:0]      ra, wa, wa_r;
  logic                we;
  logic [CNT_BITS-1:0] rd, wd, rd_cnt;
  logic [CNT_BITS-1:0] gov_r, eov_r;
  logic                hitv_r, ovf_r, rdv_r;
  logic [GB-1:0]       hit_r;
  logic                cur_el;

  pteh_ram #(.WIDTH(CNT_BITS), .DEPTH(2 * NBINS)) u_bins (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
  );

  assign ra = hd.command == CMD_READ
            ? (hd.particle_kind == KIND_ELECTRON
               ? BAB'(NBINS) + BAB'(hd.group_index) : BAB'(hd.group_index))
            : (hd_el ? BAB'(NBINS) + BAB'(hit) : BAB'(hit));
  assign cur_el = cur_r.particle_kind == KIND_ELECTRON;
  assign we = st_r == S_EXEC && hitv_r;
  assign wa = wa_r;
  assign wd = cnt_inc((cur_el ? eval_r[hit_r] : gval_r[hit_r]) ? rd : '0);

  always_comb begin
    rd_cnt = '0;
    if (rdv_r) begin
      if (32'(cur_r.group_index) == NUM_GROUPS) begin
        rd_cnt = cur_el ? eov_r : gov_r;
      end else if (cur_el ? eval_r[cur_r.group_index] : gval_r[cur_r.group_index]) begin
        rd_cnt = rd;
      end
    end
  end

  assign q_pop = st_r == S_IDLE && hd_valid && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = o_r;

  logic [ENERGY_BITS-1:0] dep;
  assign dep = ENERGY_BITS'(cur_r.energy_deposit);

  function automatic logic [ENERGY_BITS-1:0] sadd(
    input logic [ENERGY_BITS-1:0] a, input logic [ENERGY_BITS-1:0] b);
    logic [ENERGY_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sadd = s[ENERGY_BITS] ? EMAX : s[ENERGY_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      last_r <= '0;
      gcnt_r <= '0; ecnt_r <= '0; ncnt_r <= '0;
      gsum_r <= '0; esum_r <= '0; gtot_r <= '0; etot_r <= '0; psum_r <= '0;
      gval_r <= '0; eval_r <= '0;
      gov_r  <= '0; eov_r  <= '0;
      hitv_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r  <= hd;
            st_r   <= S_EXEC;
            hit_r  <= hit;
            wa_r   <= ra;
            hitv_r <= hd_close && hit != GB'(NUM_GROUPS);
            ovf_r  <= hd_close && ovf;
            rdv_r  <= hd.command == CMD_READ
                      && 32'(hd.group_index) <= NUM_GROUPS
                      && hd.particle_kind[1] == 1'b0;
            o_r.track_closed  <= hd_close;
            o_r.closed_class  <= hd_close && hd_el;
            o_r.closed_energy <= hd_close ? FIELD_E_BITS'(hd_sum) : '0;
            o_r.closed_bin    <= hd_close ? IDX_BITS'(hit) : '0;
            o_r.overflow_hit  <= hd_close && ovf;
          end
        end
        S_EXEC: begin
          st_r   <= S_DONE;
          hitv_r <= 1'b0;
          if (hitv_r) begin
            if (cur_el) eval_r[hit_r] <= 1'b1;
            else        gval_r[hit_r] <= 1'b1;
          end
          if (ovf_r) begin
            if (cur_el) eov_r <= cnt_inc(eov_r);
            else        gov_r <= cnt_inc(gov_r);
          end
          o_r.bin_count <= rd_cnt;
          if (cur_r.command == CMD_STEP) begin
            if (cur_r.track_id == TRACK_BITS'(1)) begin
              psum_r <= sadd(psum_r, dep);
            end
            if (cur_r.particle_kind[1] == 1'b0 && cur_r.track_id > TRACK_BITS'(1)) begin
              if (cur_r.track_id != last_r) begin
                last_r <= cur_r.track_id;
                if (cur_el) begin
                  ecnt_r <= cnt_inc(ecnt_r);
                  esum_r <= dep;
                end else begin
                  gcnt_r <= cnt_inc(gcnt_r);
                  gsum_r <= dep;
                end
              end else if (cur_el) begin
                esum_r <= sadd(esum_r, dep);
              end else begin
                gsum_r <= sadd(gsum_r, dep);
              end
              if (cur_el) etot_r <= sadd(etot_r, dep);
              else        gtot_r <= sadd(gtot_r, dep);
            end
            if (cur_r.particle_kind == KIND_NEUTRON && cur_r.track_id != last_r) begin
              ncnt_r <= cnt_inc(ncnt_r);
              last_r <= cur_r.track_id;
            end
          end
        end
        S_DONE: begin
          st_r <= S_IDLE;
          ov_r <= 1'b1;
          o_r.primary_energy <= FIELD_E_BITS'(psum_r);
          o_r.gamma_total    <= FIELD_E_BITS'(gtot_r);
          o_r.electron_total <= FIELD_E_BITS'(etot_r);
          o_r.neutron_tracks <= ncnt_r;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == S_EXEC) else $error("pop did not start execute");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |=> ov_r) else $error("result not presented");
endmodule
